### rtl/tlc_pkg.sv
// Shared types, register indexes and helpers for the two-road traffic light controller.
package tlc_pkg;

  localparam int DUR_W = 7;
  localparam int CNT_W = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_RED_DEFAULT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMBER_DEFAULT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_DEFAULT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION_MIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION_MAX  = 3'd4;

  localparam logic [1:0] IDX_RED   = 2'd0;
  localparam logic [1:0] IDX_AMBER = 2'd1;
  localparam logic [1:0] IDX_GREEN = 2'd2;

  localparam logic signed [CNT_W-1:0] CNT_FLOOR = -8'sd100;

  typedef logic [DUR_W-1:0] dur_t;
  typedef logic signed [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic mode_press;
    logic inc_press;
    logic set_press;
    logic phase_expired;
    logic blink_expired;
  } poll_t;

  typedef struct packed {
    logic [3:0]        ctrl_state;
    logic [3:0]        display_code;
    logic signed [7:0] count_x;
    logic signed [7:0] count_y;
    logic [6:0]        edit_value;
    logic              restart_phase_timer;
    logic              restart_blink_timer;
  } result_t;

  typedef struct packed {
    dur_t red_default;
    dur_t amber_default;
    dur_t green_default;
    dur_t duration_min;
    dur_t duration_max;
  } cfg_t;

  function automatic cnt_t dec_sat(cnt_t v);
    dec_sat = (v > CNT_FLOOR) ? cnt_t'(v - 8'sd1) : CNT_FLOOR;
  endfunction

endpackage

### rtl/tlc_stream_if.sv
// Valid/ready stream interface carrying one beat of payload.
interface tlc_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

### rtl/tlc_cfg_regs.sv
// Configuration register file: defaults and edit limits.
module tlc_cfg_regs
  import tlc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DUR_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.red_default   <= 7'd5;
      cfg.amber_default <= 7'd2;
      cfg.green_default <= 7'd3;
      cfg.duration_min  <= 7'd1;
      cfg.duration_max  <= 7'd99;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_RED_DEFAULT:   cfg.red_default   <= cfg_data;
        CFG_AMBER_DEFAULT: cfg.amber_default <= cfg_data;
        CFG_GREEN_DEFAULT: cfg.green_default <= cfg_data;
        CFG_DURATION_MIN:  cfg.duration_min  <= cfg_data;
        CFG_DURATION_MAX:  cfg.duration_max  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/tlc_core.sv
// Controller state, duration sets and per-poll next-state logic.
module tlc_core
  import tlc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  poll_t   item,
  input  cfg_t    cfg,
  output result_t res_next
);

  typedef enum logic [3:0] {
    ST_INIT       = 4'd0,
    ST_RED_GREEN  = 4'd1,
    ST_RED_AMBER  = 4'd2,
    ST_GREEN_RED  = 4'd3,
    ST_AMBER_RED  = 4'd4,
    ST_EDIT_RED   = 4'd5,
    ST_EDIT_GREEN = 4'd6,
    ST_EDIT_AMBER = 4'd7,
    ST_COMMIT     = 4'd8
  } state_t;

  typedef enum logic [3:0] {
    DSP_XRED_YGREEN = 4'd0,
    DSP_XRED_YAMBER = 4'd1,
    DSP_XGREEN_YRED = 4'd2,
    DSP_XAMBER_YRED = 4'd3,
    DSP_XRED        = 4'd4,
    DSP_YRED        = 4'd5,
    DSP_XGREEN      = 4'd6,
    DSP_YGREEN      = 4'd7,
    DSP_XAMBER      = 4'd8,
    DSP_YAMBER      = 4'd9,
    DSP_NONE        = 4'd10
  } disp_t;

  state_t state, state_next;
  disp_t  disp, disp_next;
  cnt_t   cnt_x, cnt_x_next;
  cnt_t   cnt_y, cnt_y_next;
  dur_t   act [3];
  dur_t   act_next [3];
  dur_t   pend [3];
  dur_t   pend_next [3];
  dur_t   cand [3];
  dur_t   cand_next [3];

  always_comb begin
    logic        rp, rb;
    logic [1:0]  idx;
    disp_t       shown_a, shown_b;
    logic [DUR_W:0] inc_val;
    dur_t        cand_new;
    cnt_t        lx, ly;
    logic [DUR_W:0] ag_sum;

    state_next = state;
    disp_next  = disp;
    cnt_x_next = cnt_x;
    cnt_y_next = cnt_y;
    act_next   = act;
    pend_next  = pend;
    cand_next  = cand;
    rp = 1'b0;
    rb = 1'b0;
    idx = IDX_RED;
    shown_a = DSP_XRED;
    shown_b = DSP_YRED;
    inc_val = '0;
    cand_new = '0;
    lx = cnt_x;
    ly = cnt_y;
    ag_sum = {1'b0, pend[IDX_AMBER]} + {1'b0, pend[IDX_GREEN]};

    case (state)
      ST_INIT: begin
        act_next[IDX_RED]   = cfg.red_default;
        act_next[IDX_AMBER] = cfg.amber_default;
        act_next[IDX_GREEN] = cfg.green_default;
      end
      ST_COMMIT: begin
        if ({1'b0, pend[IDX_RED]} == ag_sum) act_next = pend;
      end
      default: ;
    endcase

    case (state)
      ST_INIT, ST_COMMIT: begin
        pend_next  = act_next;
        cand_next  = act_next;
        state_next = ST_RED_GREEN;
        disp_next  = DSP_XRED_YGREEN;
        cnt_x_next = dec_sat(cnt_t'({1'b0, act_next[IDX_RED]}));
        cnt_y_next = dec_sat(cnt_t'({1'b0, act_next[IDX_GREEN]}));
        rp = 1'b1;
      end
      ST_RED_GREEN, ST_RED_AMBER, ST_GREEN_RED, ST_AMBER_RED: begin
        if (item.mode_press) begin
          state_next = ST_EDIT_RED;
          disp_next  = DSP_XRED;
          rb = 1'b1;
        end else if (item.phase_expired) begin
          rp = 1'b1;
          if (state == ST_RED_GREEN && cnt_y <= 0) begin
            state_next = ST_RED_AMBER;
            disp_next  = DSP_XRED_YAMBER;
            ly = cnt_t'({1'b0, act[IDX_AMBER]});
          end else if (state == ST_RED_AMBER && cnt_y <= 0) begin
            state_next = ST_GREEN_RED;
            disp_next  = DSP_XGREEN_YRED;
            lx = cnt_t'({1'b0, act[IDX_GREEN]});
            ly = cnt_t'({1'b0, act[IDX_RED]});
          end else if (state == ST_GREEN_RED && cnt_x <= 0) begin
            state_next = ST_AMBER_RED;
            disp_next  = DSP_XAMBER_YRED;
            lx = cnt_t'({1'b0, act[IDX_AMBER]});
          end else if (state == ST_AMBER_RED && cnt_x <= 0) begin
            state_next = ST_RED_GREEN;
            disp_next  = DSP_XRED_YGREEN;
            lx = cnt_t'({1'b0, act[IDX_RED]});
            ly = cnt_t'({1'b0, act[IDX_GREEN]});
          end
          cnt_x_next = dec_sat(lx);
          cnt_y_next = dec_sat(ly);
        end
      end
      ST_EDIT_RED, ST_EDIT_GREEN, ST_EDIT_AMBER: begin
        case (state)
          ST_EDIT_GREEN: begin
            idx = IDX_GREEN;
            shown_a = DSP_XGREEN;
            shown_b = DSP_YGREEN;
          end
          ST_EDIT_AMBER: begin
            idx = IDX_AMBER;
            shown_a = DSP_XAMBER;
            shown_b = DSP_YAMBER;
          end
          default: begin
            idx = IDX_RED;
            shown_a = DSP_XRED;
            shown_b = DSP_YRED;
          end
        endcase
        if (item.mode_press) begin
          case (state)
            ST_EDIT_RED: begin
              state_next = ST_EDIT_GREEN;
              disp_next  = DSP_XGREEN;
            end
            ST_EDIT_GREEN: begin
              state_next = ST_EDIT_AMBER;
              disp_next  = DSP_XAMBER;
            end
            default: begin
              state_next = ST_COMMIT;
              disp_next  = DSP_NONE;
            end
          endcase
        end else begin
          if (item.blink_expired) begin
            rb = 1'b1;
            disp_next = (disp == shown_a) ? shown_b : shown_a;
          end
          inc_val = {1'b0, cand[idx]} + 8'd1;
          cand_new = cand[idx];
          if (item.inc_press) begin
            cand_new = (inc_val > {1'b0, cfg.duration_max}) ? cfg.duration_min
                                                              : inc_val[DUR_W-1:0];
          end
          cand_next[idx] = cand_new;
          if (item.set_press) pend_next[idx] = cand_new;
        end
      end
      default: ;
    endcase

    res_next.ctrl_state   = state_next;
    res_next.display_code = disp_next;
    res_next.count_x      = cnt_x_next;
    res_next.count_y      = cnt_y_next;
    case (state_next)
      ST_EDIT_RED:   res_next.edit_value = cand_next[IDX_RED];
      ST_EDIT_GREEN: res_next.edit_value = cand_next[IDX_GREEN];
      ST_EDIT_AMBER: res_next.edit_value = cand_next[IDX_AMBER];
      default:       res_next.edit_value = '0;
    endcase
    res_next.restart_phase_timer = rp;
    res_next.restart_blink_timer = rb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      disp  <= DSP_XRED_YGREEN;
      cnt_x <= '0;
      cnt_y <= '0;
      act[IDX_RED]    <= 7'd5;
      act[IDX_AMBER]  <= 7'd2;
      act[IDX_GREEN]  <= 7'd3;
      pend[IDX_RED]   <= 7'd5;
      pend[IDX_AMBER] <= 7'd2;
      pend[IDX_GREEN] <= 7'd3;
      cand[IDX_RED]   <= 7'd5;
      cand[IDX_AMBER] <= 7'd2;
      cand[IDX_GREEN] <= 7'd3;
    end else if (advance) begin
      state <= state_next;
      disp  <= disp_next;
      cnt_x <= cnt_x_next;
      cnt_y <= cnt_y_next;
      act   <= act_next;
      pend  <= pend_next;
      cand  <= cand_next;
    end
  end

endmodule

### rtl/two_road_traffic_light_controller.sv
// Two-road traffic light controller top level: poll register, core, result register.
// A poll waits in the poll register until the result register can take its result.
// Throughput: one poll per cycle while the result side is ready; the poll register
// and result register form a two-stage pipe; one poll enters while a result waits.
// Reset (rst, synchronous): init state, countdowns zero, duration sets and
// configuration registers at their default values, both pipe stages empty.
module two_road_traffic_light_controller
  import tlc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  tlc_stream_if.sink           poll,
  tlc_stream_if.source         result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DUR_W-1:0]     cfg_data
);

  cfg_t    cfg;
  logic    poll_vld;
  poll_t   poll_reg;
  logic    advance;
  result_t res_next;
  logic    res_vld;
  result_t res_reg;

  tlc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance    = poll_vld && (!res_vld || result.ready);
  assign poll.ready = !poll_vld || advance;

  tlc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .item     (poll_reg),
    .cfg      (cfg),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_vld <= 1'b0;
      res_vld  <= 1'b0;
    end else begin
      if (poll.ready) poll_vld <= poll.valid;
      if (advance) begin
        res_vld <= 1'b1;
      end else if (result.ready) begin
        res_vld <= 1'b0;
      end
    end
    if (poll.ready && poll.valid) poll_reg <= poll.payload;
    if (advance) res_reg <= res_next;
  end

  assign result.valid   = res_vld;
  assign result.payload = res_reg;

endmodule

### tb/tlc_light_checker.sv
// Checker for the traffic light controller: predicts every poll's result and compares beats.
`timescale 1ns / 1ps

module tlc_light_checker
  import tlc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 poll_valid,
  input  logic                 poll_ready,
  input  poll_t                poll_data,
  input  logic                 result_valid,
  input  logic                 result_ready,
  input  result_t              result_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DUR_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   outstanding,
  output int                   results_seen,
  output int                   commits_taken
);

  localparam logic [3:0] ST_INIT       = 4'd0;
  localparam logic [3:0] ST_RED_GREEN  = 4'd1;
  localparam logic [3:0] ST_RED_AMBER  = 4'd2;
  localparam logic [3:0] ST_GREEN_RED  = 4'd3;
  localparam logic [3:0] ST_AMBER_RED  = 4'd4;
  localparam logic [3:0] ST_EDIT_RED   = 4'd5;
  localparam logic [3:0] ST_EDIT_GREEN = 4'd6;
  localparam logic [3:0] ST_EDIT_AMBER = 4'd7;
  localparam logic [3:0] ST_COMMIT     = 4'd8;

  localparam logic [3:0] DSP_XRED_YGREEN = 4'd0;
  localparam logic [3:0] DSP_XRED_YAMBER = 4'd1;
  localparam logic [3:0] DSP_XGREEN_YRED = 4'd2;
  localparam logic [3:0] DSP_XAMBER_YRED = 4'd3;
  localparam logic [3:0] DSP_XRED        = 4'd4;
  localparam logic [3:0] DSP_YRED        = 4'd5;
  localparam logic [3:0] DSP_XGREEN      = 4'd6;
  localparam logic [3:0] DSP_YGREEN      = 4'd7;
  localparam logic [3:0] DSP_XAMBER      = 4'd8;
  localparam logic [3:0] DSP_YAMBER      = 4'd9;
  localparam logic [3:0] DSP_NONE        = 4'd10;

  dur_t       dflt_red, dflt_amber, dflt_green, wrap_min, wrap_max;
  logic [3:0] light_state, lamp_code;
  cnt_t       cnt_x, cnt_y;
  dur_t       active_dur[3], pending_dur[3], candidate_dur[3];

  result_t    light_results_due[$];
  result_t    want_beat;

  initial begin
    mismatches    = 0;
    outstanding   = 0;
    results_seen  = 0;
    commits_taken = 0;
  end

  function automatic cnt_t as_count(dur_t d);
    return cnt_t'({1'b0, d});
  endfunction

  function automatic cnt_t count_down(cnt_t v);
    int t;
    t = int'(v) - 1;
    if (t < -100) t = -100;
    return cnt_t'(t);
  endfunction

  task automatic reset_model();
    dflt_red    = 7'd5;
    dflt_amber  = 7'd2;
    dflt_green  = 7'd3;
    wrap_min    = 7'd1;
    wrap_max    = 7'd99;
    light_state = ST_INIT;
    lamp_code   = DSP_XRED_YGREEN;
    cnt_x       = '0;
    cnt_y       = '0;
    active_dur[IDX_RED]   = 7'd5;
    active_dur[IDX_AMBER] = 7'd2;
    active_dur[IDX_GREEN] = 7'd3;
    for (int i = 0; i < 3; i++) begin
      pending_dur[i]   = active_dur[i];
      candidate_dur[i] = active_dur[i];
    end
  endtask

  task automatic enter_normal();
    light_state = ST_RED_GREEN;
    lamp_code   = DSP_XRED_YGREEN;
    cnt_x       = count_down(as_count(active_dur[IDX_RED]));
    cnt_y       = count_down(as_count(active_dur[IDX_GREEN]));
  endtask

  task automatic edit_step(input logic [1:0] idx, input logic [3:0] show_a,
                           input logic [3:0] show_b, input poll_t p,
                           inout logic blink_req);
    logic [7:0] bumped;
    if (p.blink_expired) begin
      blink_req = 1'b1;
      lamp_code = (lamp_code == show_a) ? show_b : show_a;
    end
    if (p.inc_press) begin
      bumped = {1'b0, candidate_dur[idx]} + 8'd1;
      candidate_dur[idx] = (bumped > {1'b0, wrap_max}) ? wrap_min : bumped[6:0];
    end
    if (p.set_press) pending_dur[idx] = candidate_dur[idx];
  endtask

  task automatic predict_lights(input poll_t p, output result_t r);
    logic       phase_req, blink_req;
    logic [7:0] amber_green;
    phase_req = 1'b0;
    blink_req = 1'b0;
    case (light_state)
      ST_INIT: begin
        active_dur[IDX_RED]   = dflt_red;
        active_dur[IDX_AMBER] = dflt_amber;
        active_dur[IDX_GREEN] = dflt_green;
        for (int i = 0; i < 3; i++) begin
          pending_dur[i]   = active_dur[i];
          candidate_dur[i] = active_dur[i];
        end
        enter_normal();
        phase_req = 1'b1;
      end
      ST_RED_GREEN, ST_RED_AMBER, ST_GREEN_RED, ST_AMBER_RED: begin
        if (p.mode_press) begin
          light_state = ST_EDIT_RED;
          lamp_code   = DSP_XRED;
          blink_req   = 1'b1;
        end else if (p.phase_expired) begin
          phase_req = 1'b1;
          case (light_state)
            ST_RED_GREEN: if (cnt_y <= 0) begin
              light_state = ST_RED_AMBER;
              lamp_code   = DSP_XRED_YAMBER;
              cnt_y       = as_count(active_dur[IDX_AMBER]);
            end
            ST_RED_AMBER: if (cnt_y <= 0) begin
              light_state = ST_GREEN_RED;
              lamp_code   = DSP_XGREEN_YRED;
              cnt_x       = as_count(active_dur[IDX_GREEN]);
              cnt_y       = as_count(active_dur[IDX_RED]);
            end
            ST_GREEN_RED: if (cnt_x <= 0) begin
              light_state = ST_AMBER_RED;
              lamp_code   = DSP_XAMBER_YRED;
              cnt_x       = as_count(active_dur[IDX_AMBER]);
            end
            ST_AMBER_RED: if (cnt_x <= 0) begin
              light_state = ST_RED_GREEN;
              lamp_code   = DSP_XRED_YGREEN;
              cnt_x       = as_count(active_dur[IDX_RED]);
              cnt_y       = as_count(active_dur[IDX_GREEN]);
            end
            default: ;
          endcase
          cnt_x = count_down(cnt_x);
          cnt_y = count_down(cnt_y);
        end
      end
      ST_EDIT_RED: begin
        if (p.mode_press) begin
          light_state = ST_EDIT_GREEN;
          lamp_code   = DSP_XGREEN;
        end else edit_step(IDX_RED, DSP_XRED, DSP_YRED, p, blink_req);
      end
      ST_EDIT_GREEN: begin
        if (p.mode_press) begin
          light_state = ST_EDIT_AMBER;
          lamp_code   = DSP_XAMBER;
        end else edit_step(IDX_GREEN, DSP_XGREEN, DSP_YGREEN, p, blink_req);
      end
      ST_EDIT_AMBER: begin
        if (p.mode_press) begin
          light_state = ST_COMMIT;
          lamp_code   = DSP_NONE;
        end else edit_step(IDX_AMBER, DSP_XAMBER, DSP_YAMBER, p, blink_req);
      end
      ST_COMMIT: begin
        // sum is one bit wider so it cannot wrap
        amber_green = {1'b0, pending_dur[IDX_AMBER]} + {1'b0, pending_dur[IDX_GREEN]};
        if ({1'b0, pending_dur[IDX_RED]} == amber_green) begin
          for (int i = 0; i < 3; i++) active_dur[i] = pending_dur[i];
          commits_taken++;
        end
        for (int i = 0; i < 3; i++) begin
          candidate_dur[i] = active_dur[i];
          pending_dur[i]   = active_dur[i];
        end
        enter_normal();
        phase_req = 1'b1;
      end
      default: ;
    endcase

    r.ctrl_state          = light_state;
    r.display_code        = lamp_code;
    r.count_x             = cnt_x;
    r.count_y             = cnt_y;
    r.restart_phase_timer = phase_req;
    r.restart_blink_timer = blink_req;
    case (light_state)
      ST_EDIT_RED:   r.edit_value = candidate_dur[IDX_RED];
      ST_EDIT_GREEN: r.edit_value = candidate_dur[IDX_GREEN];
      ST_EDIT_AMBER: r.edit_value = candidate_dur[IDX_AMBER];
      default:       r.edit_value = '0;
    endcase
  endtask

  task automatic report(input string msg);
    $display("[%0t] MISMATCH result %0d: %s", $realtime, results_seen, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) report($sformatf("%s expected %0d got %0d", name, want, got));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_model();
      light_results_due.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_RED_DEFAULT:   dflt_red   = cfg_data;
          CFG_AMBER_DEFAULT: dflt_amber = cfg_data;
          CFG_GREEN_DEFAULT: dflt_green = cfg_data;
          CFG_DURATION_MIN:  wrap_min   = cfg_data;
          CFG_DURATION_MAX:  wrap_max   = cfg_data;
          default: ;
        endcase
      end
      if (poll_valid && poll_ready) begin
        predict_lights(poll_data, want_beat);
        light_results_due.push_back(want_beat);
      end
      if (result_valid && result_ready) begin
        if (light_results_due.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          want_beat = light_results_due.pop_front();
          if ($isunknown(result_data)) report("result beat carries unknown bits");
          check_field("ctrl_state", want_beat.ctrl_state, result_data.ctrl_state);
          check_field("display_code", want_beat.display_code, result_data.display_code);
          check_field("count_x", int'(want_beat.count_x), int'(result_data.count_x));
          check_field("count_y", int'(want_beat.count_y), int'(result_data.count_y));
          check_field("edit_value", want_beat.edit_value, result_data.edit_value);
          check_field("restart_phase_timer", want_beat.restart_phase_timer,
                      result_data.restart_phase_timer);
          check_field("restart_blink_timer", want_beat.restart_blink_timer,
                      result_data.restart_blink_timer);
        end
        results_seen++;
      end
    end
    outstanding = light_results_due.size();
  end

endmodule

### tb/two_road_traffic_light_controller_tb.sv
// Testbench top for the traffic light controller: clock, reset, stimulus, verdict.
`timescale 1ns / 1ps

module two_road_traffic_light_controller_tb;
  import tlc_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 3000;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DUR_W-1:0]     cfg_data;

  int   idle_pct   = 0;
  int   stall_pct  = 0;
  int   sent_items = 0;
  int   hold_left  = 0;
  int   quiet_cycles = 0;
  int   hold_req   = 0;
  int   hold_ack   = 0;

  int   mismatches, outstanding, results_seen, commits_taken;

  tlc_stream_if #(.payload_t(poll_t))   poll_ch ();
  tlc_stream_if #(.payload_t(result_t)) res_ch ();

  two_road_traffic_light_controller dut (
    .clk       (clk),
    .rst       (rst),
    .poll      (poll_ch),
    .result    (res_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tlc_light_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .poll_valid    (poll_ch.valid),
    .poll_ready    (poll_ch.ready),
    .poll_data     (poll_ch.payload),
    .result_valid  (res_ch.valid),
    .result_ready  (res_ch.ready),
    .result_data   (res_ch.payload),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .results_seen  (results_seen),
    .commits_taken (commits_taken)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_left = HOLD_CYCLES;
      hold_ack  = hold_req;
    end
    if (hold_left > 0) begin
      res_ch.ready = 1'b0;
      hold_left--;
    end else res_ch.ready = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (poll_ch.valid && poll_ch.ready) || (res_ch.valid && res_ch.ready))
      quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic bit chance(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  task automatic send_poll(input poll_t p);
    while ($urandom_range(99) < idle_pct) begin
      poll_ch.valid   = 1'b0;
      poll_ch.payload = poll_t'($urandom_range(31));
      @(negedge clk);
    end
    poll_ch.valid   = 1'b1;
    poll_ch.payload = p;
    @(posedge clk);
    while (!poll_ch.ready) @(posedge clk);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    poll_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = DUR_W'(value);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_wrap(input int lo, input int hi);
    wait_drain();
    repeat (3) @(negedge clk);
    write_reg(CFG_DURATION_MIN, lo);
    write_reg(CFG_DURATION_MAX, hi);
  endtask

  task automatic normal_stretch(input int n);
    poll_t p;
    for (int i = 0; i < n; i++) begin
      p = poll_t'($urandom_range(31));
      p.mode_press    = 1'b0;
      p.phase_expired = chance(75);
      send_poll(p);
    end
  endtask

  // mode into edit, tweak each colour, mode out, one commit poll
  task automatic edit_sequence();
    poll_t p;
    p = poll_t'($urandom_range(31));
    p.mode_press = 1'b1;
    send_poll(p);
    for (int c = 0; c < 3; c++) begin
      repeat ($urandom_range(0, 6)) begin
        p.mode_press    = 1'b0;
        p.inc_press     = chance(50);
        p.set_press     = chance(35);
        p.phase_expired = chance(50);
        p.blink_expired = chance(40);
        send_poll(p);
      end
      p = poll_t'($urandom_range(31));
      p.mode_press = 1'b1;
      send_poll(p);
    end
    send_poll(poll_t'($urandom_range(31)));
  endtask

  task automatic random_mix(input int n);
    int goal, pick;
    goal = sent_items + n;
    while (sent_items < goal) begin
      pick = $urandom_range(99);
      if (pick < 50) normal_stretch($urandom_range(4, 40));
      else if (pick < 88) edit_sequence();
      else repeat ($urandom_range(1, 5)) send_poll(poll_t'($urandom_range(31)));
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int n);
    idle_pct  = idle;
    stall_pct = stall;
    random_mix(n);
  endtask

  initial begin
    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    poll_ch.valid   = 1'b0;
    poll_ch.payload = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // defaults land in the active set on the first poll
    write_reg(CFG_RED_DEFAULT, 0);
    write_reg(CFG_AMBER_DEFAULT, 7);
    write_reg(CFG_GREEN_DEFAULT, 127);
    write_reg(CFG_DURATION_MIN, 1);
    write_reg(CFG_DURATION_MAX, 127);

    // mode inc set tick blink
    send_poll(5'b11111);  // start-up poll ignores its bits
    send_poll(5'b00010);
    send_poll(5'b00000);
    send_poll(5'b10010);  // mode wins over tick
    send_poll(5'b00001);
    send_poll(5'b01000);
    send_poll(5'b01101);  // inc then set stores the bumped value
    send_poll(5'b00001);
    send_poll(5'b11111);  // mode in edit ignores the rest
    send_poll(5'b01000);  // green wraps past max
    send_poll(5'b00100);
    send_poll(5'b10000);
    send_poll(5'b01100);
    send_poll(5'b00001);
    send_poll(5'b10000);
    send_poll(5'b11111);  // commit rejects mismatched sum
    send_poll(5'b00010);
    send_poll(5'b00110);
    send_poll(5'b10000);
    send_poll(5'b00001);
    send_poll(5'b10000);
    send_poll(5'b10000);
    send_poll(5'b10000);
    send_poll(5'b00000);  // amber+green overflows 7 bits

    // long run of ticks drives road x down to the floor
    normal_stretch(220);
    run_phase(0, 0, 100);

    set_wrap(0, 0);
    write_reg(CFG_RED_DEFAULT, 127);
    write_reg(CFG_AMBER_DEFAULT, 0);
    write_reg(CFG_GREEN_DEFAULT, 99);
    run_phase(80, 0, 120);

    set_wrap($urandom_range(0, 3), $urandom_range(2, 8));
    run_phase(0, 80, 120);

    set_wrap(9, 4);
    run_phase(21, 21, 120);

    // back-pressure: result side holds off while polls keep coming
    idle_pct  = 0;
    stall_pct = 0;
    @(posedge clk);
    hold_req++;
    @(negedge clk);
    normal_stretch(30);
    wait_drain();

    set_wrap(1, 5);
    run_phase(0, 0, 100);

    wait_drain();
    repeat (8) @(negedge clk);
    $display("Covered %0d polls and %0d result beats across idle, stall and hold-off mixes",
             sent_items, results_seen);
    $display("Edit sessions adopted %0d new duration sets", commits_taken);
    if (mismatches == 0 && outstanding == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

### filelist.f
rtl/tlc_pkg.sv
rtl/tlc_stream_if.sv
rtl/tlc_cfg_regs.sv
rtl/tlc_core.sv
rtl/two_road_traffic_light_controller.sv
tb/tlc_light_checker.sv
tb/two_road_traffic_light_controller_tb.sv
